// ===== rtl/atrp_pkg.sv =====
// Shared types, widths and the CORDIC arc table for the accelerometer tilt block.
// No dependencies; used by atrp_cordic and accel_tilt_roll_pitch_core.
`timescale 1ns / 1ps
`default_nettype none

package atrp_pkg;

	// Defaults for the top-level parameters
	localparam int ROTATION_STEPS_DEF      = 16;
	localparam int ANGLE_FRACTION_BITS_DEF = 8;

	// Axis samples and derived widths
	localparam int DATA_W    = 16;
	localparam int SQ_W      = 2 * DATA_W - 1;           // y*y, always non-negative
	localparam int SUM_W     = SQ_W + 1;                 // y*y + z*z
	localparam int MAG_SHIFT = 16;                       // radicand scale before the root
	localparam int RAD_W     = SUM_W + MAG_SHIFT;        // even, root has RAD_W/2 bits
	localparam int X_SHIFT   = 8;                        // x scale to match the root

	// CORDIC datapath widths (magnitude growth of about 1.65 included)
	localparam int ROLL_W  = 19;
	localparam int PITCH_W = 27;

	// Angle accumulator: degrees with 16 fraction bits
	localparam int TABLE_FRACTION_BITS = 16;
	localparam int TABLE_LENGTH        = 24;
	localparam int TABLE_IDX_W         = 5;
	localparam int ACC_W               = 25;
	localparam int QUARTER_TURN        = 90 * (2 ** TABLE_FRACTION_BITS);

	localparam int ROLL_LIMIT_DEG  = 180;
	localparam int PITCH_LIMIT_DEG = 90;

	localparam int ROLL_OUT_W  = 17;
	localparam int PITCH_OUT_W = 16;

	typedef logic [TABLE_IDX_W-1:0] arc_idx_t;

	typedef struct packed {
		logic [7:0] x_high_byte;
		logic [7:0] x_low_byte;
		logic [7:0] y_high_byte;
		logic [7:0] y_low_byte;
		logic [7:0] z_high_byte;
		logic [7:0] z_low_byte;
	} sample_t;

	typedef struct packed {
		logic signed [ROLL_OUT_W-1:0]  roll_angle;
		logic signed [PITCH_OUT_W-1:0] pitch_angle;
	} angle_t;

	// atan(2^-i) in degrees, scaled by 2^16 and rounded
	function automatic logic signed [ACC_W-1:0] arc_angle(input arc_idx_t idx);
		logic signed [ACC_W-1:0] a;
		unique case (idx)
			5'd0:    a = ACC_W'(2949120);
			5'd1:    a = ACC_W'(1740967);
			5'd2:    a = ACC_W'(919879);
			5'd3:    a = ACC_W'(466945);
			5'd4:    a = ACC_W'(234379);
			5'd5:    a = ACC_W'(117304);
			5'd6:    a = ACC_W'(58666);
			5'd7:    a = ACC_W'(29335);
			5'd8:    a = ACC_W'(14668);
			5'd9:    a = ACC_W'(7334);
			5'd10:   a = ACC_W'(3667);
			5'd11:   a = ACC_W'(1833);
			5'd12:   a = ACC_W'(917);
			5'd13:   a = ACC_W'(458);
			5'd14:   a = ACC_W'(229);
			5'd15:   a = ACC_W'(115);
			5'd16:   a = ACC_W'(57);
			5'd17:   a = ACC_W'(29);
			5'd18:   a = ACC_W'(14);
			5'd19:   a = ACC_W'(7);
			5'd20:   a = ACC_W'(4);
			5'd21:   a = ACC_W'(2);
			5'd22:   a = ACC_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/atrp_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side payload.
// Depends on nothing outside itself; instantiated by accel_tilt_roll_pitch_core.
`timescale 1ns / 1ps
`default_nettype none

module atrp_isqrt #(
	parameter int IN_W   = 48,
	parameter int SIDE_W = 48
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [IN_W-1:0]   radicand,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic [IN_W/2-1:0]      root,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int STEPS = IN_W / 2;

	logic [IN_W-1:0]   rem_s  [STEPS];
	logic [IN_W-1:0]   res_s  [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [IN_W-1:0] BIT = IN_W'(1) << (IN_W - 2 - 2 * k);

		logic [IN_W-1:0]   rem_in;
		logic [IN_W-1:0]   res_in;
		logic [SIDE_W-1:0] side_k;
		logic [IN_W-1:0]   trial;
		logic              take;

		if (k == 0) begin : g_first
			assign rem_in = radicand;
			assign res_in = '0;
			assign side_k = side_in;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
			assign side_k = side_s[k-1];
		end

		assign trial = res_in + BIT;
		assign take  = (rem_in >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? (rem_in - trial) : rem_in;
				res_s[k]  <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
				side_s[k] <= side_k;
			end
		end
	end

	assign root     = res_s[STEPS-1][IN_W/2-1:0];
	assign side_out = side_s[STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/atrp_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(yv, xv) in degrees with 16 fraction bits.
// Uses atrp_pkg for the arc table and accumulator width.
`timescale 1ns / 1ps
`default_nettype none

module atrp_cordic #(
	parameter int W     = 19,
	parameter int STEPS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [W-1:0]            xv,
	input  wire logic signed [W-1:0]            yv,
	output logic signed [atrp_pkg::ACC_W-1:0]   angle
);

	localparam logic signed [atrp_pkg::ACC_W-1:0] QUARTER =
		atrp_pkg::ACC_W'(atrp_pkg::QUARTER_TURN);

	logic signed [W-1:0]               cx_s   [STEPS+1];
	logic signed [W-1:0]               cy_s   [STEPS+1];
	logic signed [atrp_pkg::ACC_W-1:0] acc_s  [STEPS+1];
	logic                              zero_s [STEPS+1];

	// Turn a left-half-plane vector by 90 degrees into the right half plane
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (xv == '0) && (yv == '0);
			if (xv[W-1]) begin
				if (!yv[W-1]) begin
					cx_s[0]  <= yv;
					cy_s[0]  <= -xv;
					acc_s[0] <= QUARTER;
				end else begin
					cx_s[0]  <= -yv;
					cy_s[0]  <= xv;
					acc_s[0] <= -QUARTER;
				end
			end else begin
				cx_s[0]  <= xv;
				cy_s[0]  <= yv;
				acc_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_rot
		logic signed [W-1:0]               dx;
		logic signed [W-1:0]               dy;
		logic signed [atrp_pkg::ACC_W-1:0] arc;

		assign dx  = cy_s[k] >>> k;
		assign dy  = cx_s[k] >>> k;
		assign arc = atrp_pkg::arc_angle(atrp_pkg::arc_idx_t'(k));

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k+1] <= zero_s[k];
				if (!cy_s[k][W-1]) begin
					cx_s[k+1]  <= cx_s[k] + dx;
					cy_s[k+1]  <= cy_s[k] - dy;
					acc_s[k+1] <= acc_s[k] + arc;
				end else begin
					cx_s[k+1]  <= cx_s[k] - dx;
					cy_s[k+1]  <= cy_s[k] + dy;
					acc_s[k+1] <= acc_s[k] - arc;
				end
			end
		end
	end

	// A zero vector has no direction: report 0
	assign angle = zero_s[STEPS] ? '0 : acc_s[STEPS];

endmodule

`default_nettype wire

// ===== rtl/accel_tilt_roll_pitch_core.sv =====
// Roll and pitch from one raw accelerometer sample. One sample per cycle unless a
// finished result waits on a stalled consumer: squares, a 24-stage bit-per-stage
// root and one register stage per CORDIC micro-rotation, all advancing on one
// shared enable. arst_n clears the stage valid bits and the output valid; data
// registers are not reset. Uses atrp_pkg, atrp_isqrt and atrp_cordic.
`timescale 1ns / 1ps
`default_nettype none

module accel_tilt_roll_pitch_core #(
	parameter int ROTATION_STEPS      = atrp_pkg::ROTATION_STEPS_DEF,
	parameter int ANGLE_FRACTION_BITS = atrp_pkg::ANGLE_FRACTION_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              sample_valid,
	output logic                   sample_ready,
	input  wire atrp_pkg::sample_t sample,
	output logic                   angle_valid,
	input  wire logic              angle_ready,
	output atrp_pkg::angle_t       angle
);

	localparam int DATA_W   = atrp_pkg::DATA_W;
	localparam int ACC_W    = atrp_pkg::ACC_W;
	localparam int RAD_W    = atrp_pkg::RAD_W;
	localparam int ROOT_W   = RAD_W / 2;
	localparam int SIDE_W   = 3 * DATA_W;
	localparam int PIPE_N   = 3 + ROOT_W + 1 + ROTATION_STEPS;
	localparam int SHIFT    = atrp_pkg::TABLE_FRACTION_BITS - ANGLE_FRACTION_BITS;

	localparam logic signed [ACC_W:0] HALF = (ACC_W + 1)'(1) << (SHIFT - 1);
	localparam logic signed [ACC_W:0] ROLL_LIM =
		(ACC_W + 1)'(atrp_pkg::ROLL_LIMIT_DEG) << ANGLE_FRACTION_BITS;
	localparam logic signed [ACC_W:0] PITCH_LIM =
		(ACC_W + 1)'(atrp_pkg::PITCH_LIMIT_DEG) << ANGLE_FRACTION_BITS;

	// Round to nearest, ties upward, then clamp to +-lim
	function automatic logic signed [ACC_W:0] to_fixed(
		input logic signed [ACC_W-1:0] acc,
		input logic signed [ACC_W:0]   lim
	);
		logic signed [ACC_W:0] r;
		r = ((ACC_W + 1)'(acc) + HALF) >>> SHIFT;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	logic              en;
	logic [PIPE_N-1:0] valid_s;
	logic              angle_valid_q;
	atrp_pkg::angle_t  angle_q;

	// Stage 1: joined axes
	logic signed [DATA_W-1:0] x_s1, y_s1, z_s1;
	// Stage 2: squares
	logic signed [DATA_W-1:0]      x_s2, y_s2, z_s2;
	logic [atrp_pkg::SQ_W-1:0]     yy_s2, zz_s2;
	logic signed [2*DATA_W-1:0]    y_prod, z_prod;
	// Stage 3: scaled radicand
	logic signed [DATA_W-1:0] x_s3, y_s3, z_s3;
	logic [RAD_W-1:0]         rad_s3;
	logic [atrp_pkg::SUM_W-1:0] sq_sum;

	logic [ROOT_W-1:0]         root;
	logic [SIDE_W-1:0]         side_out;
	logic signed [DATA_W-1:0]  x_d, y_d, z_d;
	logic signed [DATA_W+atrp_pkg::X_SHIFT-1:0] x_scaled;
	logic signed [ACC_W-1:0]   roll_acc, pitch_acc;
	logic signed [ACC_W:0]     roll_fix, pitch_fix;

	// Advance everything unless a finished result waits on a stalled consumer
	assign en           = !angle_valid_q || angle_ready;
	assign sample_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s       <= '0;
			angle_valid_q <= 1'b0;
		end else if (en) begin
			valid_s       <= {valid_s[PIPE_N-2:0], sample_valid};
			angle_valid_q <= valid_s[PIPE_N-1];
		end
	end

	assign y_prod = y_s1 * y_s1;
	assign z_prod = z_s1 * z_s1;
	assign sq_sum = atrp_pkg::SUM_W'(yy_s2) + atrp_pkg::SUM_W'(zz_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= {sample.x_high_byte, sample.x_low_byte};
			y_s1   <= {sample.y_high_byte, sample.y_low_byte};
			z_s1   <= {sample.z_high_byte, sample.z_low_byte};

			x_s2   <= x_s1;
			y_s2   <= y_s1;
			z_s2   <= z_s1;
			yy_s2  <= y_prod[atrp_pkg::SQ_W-1:0];
			zz_s2  <= z_prod[atrp_pkg::SQ_W-1:0];

			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
			rad_s3 <= {sq_sum, {atrp_pkg::MAG_SHIFT{1'b0}}};
		end
	end

	atrp_isqrt #(
		.IN_W   (RAD_W),
		.SIDE_W (SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (rad_s3),
		.side_in  ({x_s3, y_s3, z_s3}),
		.root     (root),
		.side_out (side_out)
	);

	assign {x_d, y_d, z_d} = side_out;
	assign x_scaled        = {x_d, {atrp_pkg::X_SHIFT{1'b0}}};

	atrp_cordic #(
		.W     (atrp_pkg::ROLL_W),
		.STEPS (ROTATION_STEPS)
	) u_roll (
		.clk   (clk),
		.en    (en),
		.xv    (atrp_pkg::ROLL_W'(z_d)),
		.yv    (atrp_pkg::ROLL_W'(y_d)),
		.angle (roll_acc)
	);

	atrp_cordic #(
		.W     (atrp_pkg::PITCH_W),
		.STEPS (ROTATION_STEPS)
	) u_pitch (
		.clk   (clk),
		.en    (en),
		.xv    (signed'(atrp_pkg::PITCH_W'(root))),
		.yv    (atrp_pkg::PITCH_W'(x_scaled)),
		.angle (pitch_acc)
	);

	assign roll_fix  = to_fixed(roll_acc, ROLL_LIM);
	assign pitch_fix = to_fixed(pitch_acc, PITCH_LIM);

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q.roll_angle  <= roll_fix[atrp_pkg::ROLL_OUT_W-1:0];
			angle_q.pitch_angle <= pitch_fix[atrp_pkg::PITCH_OUT_W-1:0];
		end
	end

	assign angle_valid = angle_valid_q;
	assign angle       = angle_q;

endmodule

`default_nettype wire
